// ----- hdl/ssag_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the slice address generator.
`timescale 1ns / 1ps

package ssag_pkg;

  localparam int unsigned MAX_RANK    = 4;
  localparam int unsigned AXIS_W      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned RANK_W      = 3;
  localparam int unsigned EFF_W       = RANK_W + 1;
  localparam int unsigned SIZE_BITS   = 16;
  localparam int unsigned IDX_W       = SIZE_BITS + 1;
  localparam int unsigned SEL_W       = 3;
  localparam int unsigned BOUND_W     = 32;
  localparam int unsigned STEP_W      = 17;
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned OFF_OUT_W   = 32;
  localparam int unsigned POS_W       = 32;

  // Input item tdata layout, lowest bit first.
  localparam int unsigned SEL_LSB     = 0;
  localparam int unsigned SIZE_LSB    = SEL_LSB + SEL_W;
  localparam int unsigned START_LSB   = SIZE_LSB + SIZE_BITS;
  localparam int unsigned END_LSB     = START_LSB + BOUND_W;
  localparam int unsigned STEP_LSB    = END_LSB + BOUND_W;
  localparam int unsigned IN_FIELDS_W = STEP_LSB + STEP_W;
  localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned OUT_FIELDS_W = OFF_OUT_W + POS_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_NEXT = 1'b1
  } ssag_func_e;

  typedef enum logic [1:0] {
    SLC_OK        = 2'd0,
    SLC_ZERO_STEP = 2'd1,
    SLC_EMPTY     = 2'd2,
    SLC_DONE      = 2'd3
  } ssag_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_STRIDE,
    S_MAC,
    S_ACC,
    S_EMIT
  } ssag_state_e;

  typedef struct packed {
    logic                capture;
    logic                load_axis;
    logic                stride_init;
    logic                stride_step;
    logic                walk_begin;
    logic                mac_clear;
    logic                mac_step;
    logic                mac_flush;
    logic                emit;
    ssag_status_e        emit_status;
    logic [AXIS_W-1:0]   axis;
  } ssag_cmd_t;

  typedef struct packed {
    ssag_func_e          func;
    logic                zero_step;
    logic                axis_ok;
    logic                walk_active;
    logic                walk_finished;
    logic                slice_empty;
    logic                out_free;
    logic [AXIS_W-1:0]   last_axis;
  } ssag_stat_t;

endpackage

// ----- hdl/strided_slice_address_generator.sv -----
// Top level of the strided tensor slice address generator.
`timescale 1ns / 1ps

// Walks a strided slice of a tensor of up to four axes in row-major order and
// hands out, per request, the input element offset (mod 2^32), the output
// index and a last flag. A load item (tuser 0) stores one axis descriptor:
// negative start/end wrap by the size, then clamp to 0..size for a positive
// step or -1..size-1 for a negative one; a zero step answers status 1 and
// stores nothing, and a load whose axis is out of range is dropped unanswered.
// A next item (tuser 1) answers one element (status 0), or status 2 if some
// axis in use is empty, or status 3 once the last element is out, until a
// stored load or a rank write starts over. Writing rank_in_use (cfg_we_i)
// also cancels the walk; do it only while the block is idle. The effective
// rank runs 1..4. Two multipliers each sweep the axes one per cycle: one
// builds the strides at the start of a walk, the other sums index times
// stride for each element. A finished result waits in the output register
// while the next item is taken.

module strided_slice_address_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: axis_select[2:0], axis_size[18:3], start_value[50:19],
  //        end_value[82:51], step_value[99:83], zero fill[103:100]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ssag_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: func (0 load axis, 1 next offset)
  input  logic                                s_axis_tuser,
  // tdata: elem_offset[31:0], output_position[63:32]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ssag_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  // tuser: status[1:0]
  output logic [1:0]                          m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [ssag_pkg::RANK_W-1:0]         cfg_wdata_i
);
  import ssag_pkg::*;

  ssag_cmd_t  cmd;
  ssag_stat_t stat;

  // control: accept, decode, sequence stride build, multiply sweep and emit
  ssag_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // datapath: descriptors, clamp, strides, offset sum and output register
  ssag_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .m_user_o    (m_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ----- hdl/ssag_ctrl.sv -----
// Sequencing state machine of the slice address generator.
`timescale 1ns / 1ps

module ssag_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  ssag_pkg::ssag_stat_t stat_i,
  output ssag_pkg::ssag_cmd_t  cmd_o
);
  import ssag_pkg::*;

  ssag_state_e       state_q, state_d;
  logic [AXIS_W-1:0] cnt_q, cnt_d;
  ssag_status_e      code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      code_q  <= SLC_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    code_d            = code_q;
    s_ready_o         = 1'b0;
    cmd_o             = '0;
    cmd_o.axis        = cnt_q;
    cmd_o.emit_status = code_q;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.func == FUNC_LOAD) begin
          if (stat_i.zero_step) begin
            code_d  = SLC_ZERO_STEP;
            state_d = S_EMIT;
          end else begin
            cmd_o.load_axis = stat_i.axis_ok;
            state_d         = S_IDLE;
          end
        end else if (stat_i.walk_finished) begin
          code_d  = SLC_DONE;
          state_d = S_EMIT;
        end else if (stat_i.walk_active) begin
          code_d          = SLC_OK;
          cmd_o.mac_clear = 1'b1;
          cnt_d           = '0;
          state_d         = S_MAC;
        end else if (stat_i.slice_empty) begin
          code_d  = SLC_EMPTY;
          state_d = S_EMIT;
        end else begin
          // fresh walk: build strides from the innermost axis outward
          code_d            = SLC_OK;
          cmd_o.stride_init = 1'b1;
          cnt_d             = stat_i.last_axis;
          state_d           = S_STRIDE;
        end
      end
      S_STRIDE: begin
        cmd_o.stride_step = 1'b1;
        if (cnt_q == '0) begin
          cmd_o.walk_begin = 1'b1;
          cmd_o.mac_clear  = 1'b1;
          state_d          = S_MAC;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (cnt_q == stat_i.last_axis) begin
          state_d = S_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ACC: begin
        cmd_o.mac_flush = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ssag_datapath.sv -----
// Descriptor store, clamp logic, stride builder, offset multiply-accumulate and output register.
`timescale 1ns / 1ps

module ssag_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ssag_pkg::IN_DATA_W-1:0]      s_data_i,
  input  logic                                s_user_i,
  input  logic                                cfg_we_i,
  input  logic [ssag_pkg::RANK_W-1:0]         cfg_wdata_i,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic [ssag_pkg::OUT_DATA_W-1:0]     m_data_o,
  output logic                                m_last_o,
  output logic [1:0]                          m_user_o,
  input  ssag_pkg::ssag_cmd_t                 cmd_i,
  output ssag_pkg::ssag_stat_t                stat_o
);
  import ssag_pkg::*;

  localparam int unsigned CL_W  = BOUND_W + 2;
  localparam int unsigned SW_W  = EFF_W + 1;
  localparam int unsigned NXT_W = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;

  // captured input item
  ssag_func_e                func_q;
  logic signed [SEL_W-1:0]   sel_q;
  logic [SIZE_BITS-1:0]      size_q;
  logic signed [BOUND_W-1:0] start_q;
  logic signed [BOUND_W-1:0] end_q;
  logic signed [STEP_W-1:0]  step_q;

  logic [RANK_W-1:0]         rank_q;

  // per-axis descriptors and walk position
  logic [SIZE_BITS-1:0]      dim_q   [MAX_RANK];
  logic signed [IDX_W-1:0]   first_q [MAX_RANK];
  logic signed [IDX_W-1:0]   limit_q [MAX_RANK];
  logic signed [STEP_W-1:0]  inc_q   [MAX_RANK];
  logic [OFFSET_BITS-1:0]    pitch_q [MAX_RANK];
  logic signed [IDX_W-1:0]   idx_q   [MAX_RANK];

  logic [OFFSET_BITS-1:0]    run_q;
  logic [OFFSET_BITS-1:0]    prod_q;
  logic [OFFSET_BITS-1:0]    acc_q;
  logic [POS_W-1:0]          pos_q;
  logic                      active_q;
  logic                      finished_q;

  logic                      m_valid_q;
  logic [OFF_OUT_W-1:0]      m_off_q;
  logic [POS_W-1:0]          m_pos_q;
  logic                      m_last_q;
  ssag_status_e              m_user_q;

  logic [EFF_W-1:0]          eff_rank;
  logic signed [SW_W-1:0]    rank_s;
  logic signed [SW_W-1:0]    sel_ext;
  logic signed [SW_W-1:0]    sel_w;
  logic                      axis_ok;
  logic [AXIS_W-1:0]         load_axis;

  logic signed [CL_W-1:0]    dim_s, s_w, e_w, lo, hi, s_c, e_c;
  logic                      step_pos;

  logic [MAX_RANK-1:0]       in_use, ax_empty, wrap, bump;
  logic signed [NXT_W-1:0]   nxt [MAX_RANK];
  logic                      walk_last;
  logic                      emit_ok;
  logic                      out_free;

  // effective rank: zero acts as one, anything above MAX_RANK saturates
  always_comb begin
    if (rank_q == '0) begin
      eff_rank = EFF_W'(1);
    end else if ({1'b0, rank_q} > EFF_W'(MAX_RANK)) begin
      eff_rank = EFF_W'(MAX_RANK);
    end else begin
      eff_rank = {1'b0, rank_q};
    end
  end

  // negative axis selects count back from the rank
  always_comb begin
    rank_s  = signed'({1'b0, eff_rank});
    sel_ext = SW_W'(sel_q);
    sel_w   = sel_q[SEL_W-1] ? (sel_ext + rank_s) : sel_ext;
    axis_ok = !sel_w[SW_W-1] && (sel_w < rank_s);
    load_axis = sel_w[AXIS_W-1:0];
  end

  // wrap negative bounds by the size, then clamp to the step's range
  always_comb begin
    step_pos = !step_q[STEP_W-1];
    dim_s    = signed'(CL_W'(size_q));
    s_w      = CL_W'(start_q);
    e_w      = CL_W'(end_q);
    if (start_q[BOUND_W-1]) begin
      s_w = s_w + dim_s;
    end
    if (end_q[BOUND_W-1]) begin
      e_w = e_w + dim_s;
    end
    lo  = step_pos ? CL_W'(0) : -CL_W'(1);
    hi  = step_pos ? dim_s : (dim_s - CL_W'(1));
    s_c = (s_w < lo) ? lo : ((s_w > hi) ? hi : s_w);
    e_c = (e_w < lo) ? lo : ((e_w > hi) ? hi : e_w);
  end

  // per-axis emptiness, next index and wrap, then the carry chain
  always_comb begin
    logic c;
    c = 1'b1;
    for (int a = 0; a < MAX_RANK; a++) begin
      in_use[a]   = EFF_W'(a) < eff_rank;
      ax_empty[a] = inc_q[a][STEP_W-1] ? (first_q[a] <= limit_q[a])
                                       : (first_q[a] >= limit_q[a]);
      nxt[a]      = NXT_W'(idx_q[a]) + NXT_W'(inc_q[a]);
      wrap[a]     = inc_q[a][STEP_W-1] ? (nxt[a] <= NXT_W'(limit_q[a]))
                                       : (nxt[a] >= NXT_W'(limit_q[a]));
    end
    for (int a = MAX_RANK - 1; a >= 0; a--) begin
      bump[a] = 1'b0;
      if (in_use[a]) begin
        bump[a] = c;
        c       = c & wrap[a];
      end
    end
    walk_last = c;
  end

  assign emit_ok  = cmd_i.emit && (cmd_i.emit_status == SLC_OK);
  assign out_free = !m_valid_q || m_ready_i;

  // payload capture and output register load
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= ssag_func_e'(s_user_i);
      sel_q   <= s_data_i[SEL_LSB +: SEL_W];
      size_q  <= s_data_i[SIZE_LSB +: SIZE_BITS];
      start_q <= s_data_i[START_LSB +: BOUND_W];
      end_q   <= s_data_i[END_LSB +: BOUND_W];
      step_q  <= s_data_i[STEP_LSB +: STEP_W];
    end
    if (cmd_i.emit) begin
      m_user_q <= cmd_i.emit_status;
      if (cmd_i.emit_status == SLC_OK) begin
        m_off_q  <= OFF_OUT_W'(acc_q);
        m_pos_q  <= pos_q;
        m_last_q <= walk_last;
      end else begin
        m_off_q  <= '0;
        m_pos_q  <= '0;
        m_last_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q     <= RANK_W'(1);
      for (int a = 0; a < MAX_RANK; a++) begin
        dim_q[a]   <= SIZE_BITS'(1);
        first_q[a] <= '0;
        limit_q[a] <= IDX_W'(1);
        inc_q[a]   <= STEP_W'(1);
        pitch_q[a] <= OFFSET_BITS'(1);
        idx_q[a]   <= '0;
      end
      run_q      <= '0;
      prod_q     <= '0;
      acc_q      <= '0;
      pos_q      <= '0;
      active_q   <= 1'b0;
      finished_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end

      if (cmd_i.load_axis) begin
        dim_q[load_axis]   <= size_q;
        first_q[load_axis] <= s_c[IDX_W-1:0];
        limit_q[load_axis] <= e_c[IDX_W-1:0];
        inc_q[load_axis]   <= step_q;
      end

      if (cmd_i.stride_init) begin
        run_q <= OFFSET_BITS'(1);
      end else if (cmd_i.stride_step) begin
        pitch_q[cmd_i.axis] <= run_q;
        run_q               <= run_q * OFFSET_BITS'(dim_q[cmd_i.axis]);
      end

      for (int a = 0; a < MAX_RANK; a++) begin
        if (cmd_i.walk_begin) begin
          idx_q[a] <= first_q[a];
        end else if (emit_ok && bump[a]) begin
          idx_q[a] <= wrap[a] ? first_q[a] : nxt[a][IDX_W-1:0];
        end
      end

      if (cmd_i.mac_clear) begin
        prod_q <= '0;
        acc_q  <= '0;
      end else if (cmd_i.mac_step) begin
        prod_q <= OFFSET_BITS'(idx_q[cmd_i.axis][SIZE_BITS-1:0]) * pitch_q[cmd_i.axis];
        acc_q  <= acc_q + prod_q;
      end else if (cmd_i.mac_flush) begin
        acc_q <= acc_q + prod_q;
      end

      if (cmd_i.walk_begin) begin
        pos_q <= '0;
      end else if (emit_ok) begin
        pos_q <= pos_q + 1'b1;
      end

      if (cfg_we_i || cmd_i.load_axis) begin
        active_q   <= 1'b0;
        finished_q <= 1'b0;
      end else if (cmd_i.walk_begin) begin
        active_q <= 1'b1;
      end else if (emit_ok && walk_last) begin
        active_q   <= 1'b0;
        finished_q <= 1'b1;
      end

      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o               = '0;
    stat_o.func          = func_q;
    stat_o.zero_step     = (step_q == '0);
    stat_o.axis_ok       = axis_ok;
    stat_o.walk_active   = active_q;
    stat_o.walk_finished = finished_q;
    stat_o.slice_empty   = |(ax_empty & in_use);
    stat_o.out_free      = out_free;
    stat_o.last_axis     = AXIS_W'(eff_rank - 1'b1);
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = OUT_DATA_W'({m_pos_q, m_off_q});
  assign m_last_o  = m_last_q;
  assign m_user_o  = m_user_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(active_q && finished_q))
    else $error("walk active and finished at once");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwrites an item still waiting");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_user_q != SLC_OK)) |-> (m_off_q == '0 && m_pos_q == '0 && !m_last_q))
    else $error("status item carries payload");

  a_last_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_ok && walk_last && !cfg_we_i) |=> (finished_q && !active_q))
    else $error("last element did not finish the walk");

endmodule

// ----- test/ssag_slice_checker.sv -----
// Scoreboard for the slice address generator: predicts each answer and compares it.
`timescale 1ns / 1ps

module ssag_slice_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [ssag_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [ssag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,
  input  logic [1:0]                      m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [ssag_pkg::RANK_W-1:0]     cfg_wdata_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o
);
  import ssag_pkg::*;

  typedef struct packed {
    logic [OFF_OUT_W-1:0] offset;
    logic [POS_W-1:0]     position;
    logic                 last;
    ssag_status_e         status;
  } slice_answer_t;

  slice_answer_t answers_q[$];

  // Mirror of the slice descriptors and the walk.
  logic [RANK_W-1:0]         rank_q;
  logic [SIZE_BITS-1:0]      extent_q [MAX_RANK];
  logic signed [IDX_W-1:0]   first_q  [MAX_RANK];
  logic signed [IDX_W-1:0]   limit_q  [MAX_RANK];
  logic signed [STEP_W-1:0]  stride_q [MAX_RANK];
  logic [OFFSET_BITS-1:0]    pitch_q  [MAX_RANK];
  longint                    coord_q  [MAX_RANK];
  logic [POS_W-1:0]          out_index_q;
  bit                        walk_on_q;
  bit                        walk_done_q;

  function automatic int active_rank();
    if (rank_q == '0) return 1;
    if (int'(rank_q) > int'(MAX_RANK)) return int'(MAX_RANK);
    return int'(rank_q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint elements_along(int a);
    longint s, e, st;
    s  = longint'(first_q[a]);
    e  = longint'(limit_q[a]);
    st = longint'(stride_q[a]);
    if (st > 0) return (s >= e) ? 0 : (e - s - 1) / st + 1;
    if (st < 0) return (s <= e) ? 0 : (s - e - 1) / (-st) + 1;
    return 0;
  endfunction

  function automatic void push_answer(logic [31:0] offset, logic [31:0] position,
                                      logic last, ssag_status_e status);
    slice_answer_t ans;
    ans.offset   = offset;
    ans.position = position;
    ans.last     = last;
    ans.status   = status;
    answers_q    = {answers_q, ans};
  endfunction

  // Apply one accepted item to the mirror and queue the answer it causes.
  function automatic void predict_slice_item(ssag_func_e func, logic [IN_DATA_W-1:0] data);
    int     r;
    longint sel, dim, s, e, st, pitch, total;
    bit     carry;
    r = active_rank();
    if (func == FUNC_LOAD) begin
      sel = longint'($signed(data[SEL_LSB +: SEL_W]));
      dim = longint'(data[SIZE_LSB +: SIZE_BITS]);
      s   = longint'($signed(data[START_LSB +: BOUND_W]));
      e   = longint'($signed(data[END_LSB +: BOUND_W]));
      st  = longint'($signed(data[STEP_LSB +: STEP_W]));
      // a zero step is rejected before the axis is even looked at
      if (st == 0) begin
        push_answer('0, '0, 1'b0, SLC_ZERO_STEP);
        return;
      end
      if (sel < 0) sel += longint'(r);
      if (sel < 0 || sel >= longint'(r)) return;
      if (s < 0) s += dim;
      if (e < 0) e += dim;
      if (st > 0) begin
        s = clip(s, 0, dim);
        e = clip(e, 0, dim);
      end else begin
        s = clip(s, -1, dim - 1);
        e = clip(e, -1, dim - 1);
      end
      extent_q[sel] = SIZE_BITS'(dim);
      first_q[sel]  = IDX_W'(s);
      limit_q[sel]  = IDX_W'(e);
      stride_q[sel] = STEP_W'(st);
      walk_on_q   = 1'b0;
      walk_done_q = 1'b0;
      return;
    end

    if (walk_done_q) begin
      push_answer('0, '0, 1'b0, SLC_DONE);
      return;
    end
    if (!walk_on_q) begin
      for (int a = 0; a < r; a++) begin
        if (elements_along(a) == 0) begin
          push_answer('0, '0, 1'b0, SLC_EMPTY);
          return;
        end
      end
      pitch = 1;
      for (int a = r - 1; a >= 0; a--) begin
        pitch_q[a] = OFFSET_BITS'(pitch);
        pitch = (pitch * longint'(extent_q[a])) & 64'hFFFF_FFFF;
      end
      for (int a = 0; a < int'(MAX_RANK); a++) coord_q[a] = 0;
      out_index_q = '0;
      walk_on_q   = 1'b1;
    end
    total = 0;
    for (int a = 0; a < r; a++)
      total += (longint'(first_q[a]) + coord_q[a] * longint'(stride_q[a])) *
               longint'(pitch_q[a]);
    // advance the coordinates like an odometer, innermost axis first
    carry = 1'b1;
    for (int a = r - 1; a >= 0 && carry; a--) begin
      coord_q[a] += 1;
      if (coord_q[a] >= elements_along(a)) coord_q[a] = 0;
      else carry = 1'b0;
    end
    push_answer(total[31:0], out_index_q, carry, SLC_OK);
    out_index_q = out_index_q + 1'b1;
    if (carry) begin
      walk_on_q   = 1'b0;
      walk_done_q = 1'b1;
    end
  endfunction

  function automatic void report(string what, slice_answer_t want, slice_answer_t got);
    if (errors_o < 10)
      $display("[%0t] %s: expected off=%h pos=%0d last=%b st=%0d, got off=%h pos=%0d last=%b st=%0d",
               $time, what, want.offset, want.position, want.last, want.status,
               got.offset, got.position, got.last, got.status);
    errors_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slice_answer_t got, want;
    if (!rst_ni) begin
      rank_q = 3'd1;
      for (int a = 0; a < int'(MAX_RANK); a++) begin
        extent_q[a] = SIZE_BITS'(1);
        first_q[a]  = '0;
        limit_q[a]  = IDX_W'(1);
        stride_q[a] = STEP_W'(1);
        pitch_q[a]  = OFFSET_BITS'(1);
        coord_q[a]  = 0;
      end
      out_index_q = '0;
      walk_on_q   = 1'b0;
      walk_done_q = 1'b0;
      answers_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.offset   = m_axis_tdata[OFF_OUT_W-1:0];
        got.position = m_axis_tdata[OFF_OUT_W +: POS_W];
        got.last     = m_axis_tlast;
        got.status   = ssag_status_e'(m_axis_tuser);
        if (answers_q.size() == 0) begin
          report("unexpected item", '0, got);
        end else begin
          want = answers_q.pop_front();
          if (got !== want) report("mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_slice_item(ssag_func_e'(s_axis_tuser), s_axis_tdata);
      if (cfg_we_i) begin
        rank_q      = cfg_wdata_i;
        walk_on_q   = 1'b0;
        walk_done_q = 1'b0;
      end
      pending_o = answers_q.size();
    end
  end

endmodule

// ----- test/tb_strided_slice_address_generator.sv -----
// Testbench top for the strided slice address generator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_strided_slice_address_generator;
  import ssag_pkg::*;

  // Rough number of items to send in the random part, spread over four phases.
  localparam int unsigned ITEM_GOAL = 1750;
  // Slowest item is a first element at rank four; leave margin.
  localparam int unsigned SETTLE_CYCLES = 24;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_we_i    = 1'b0;
  logic [RANK_W-1:0]     cfg_wdata_i = '0;

  int unsigned errors;
  int unsigned pending;

  // Flow control knobs, in percent of cycles.
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned items_sent = 0;
  // Rank as last written, used only to aim loads at axes in use.
  int unsigned cur_rank   = 1;

  strided_slice_address_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  ssag_slice_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always #2 clk_i = ~clk_i;

  // Receiver side: pick a fresh ready every cycle.
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // Offer one item and hold it until the block takes it. Enter and leave on a
  // falling edge; valid stays high on exit so back-to-back items need no gap.
  task automatic push_item(ssag_func_e func, logic [IN_DATA_W-1:0] data);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic load_axis(int sel, int unsigned size, int start, int stop, int step_v);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[SEL_LSB +: SEL_W]       = sel[SEL_W-1:0];
    data[SIZE_LSB +: SIZE_BITS]  = size[SIZE_BITS-1:0];
    data[START_LSB +: BOUND_W]   = start;
    data[END_LSB +: BOUND_W]     = stop;
    data[STEP_LSB +: STEP_W]     = step_v[STEP_W-1:0];
    push_item(FUNC_LOAD, data);
  endtask

  // The block ignores the payload of a request; fill it with noise anyway.
  task automatic request_next();
    logic [IN_DATA_W-1:0] data;
    data = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
    data[IN_DATA_W-1:IN_FIELDS_W] = '0;
    push_item(FUNC_NEXT, data);
  endtask

  // Drain, let the block settle, then write the rank register for one cycle.
  task automatic write_rank(int unsigned rank);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rank[RANK_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_rank = rank;
  endtask

  // Well-formed slice: load every axis in use (now and then skip one), then
  // walk it, usually a little past the end to hit the finished status.
  task automatic random_slice();
    int unsigned r, bound, n, size, mag;
    int          lo, hi, start, stop, step_v, swap;
    r = (cur_rank == 0) ? 1 : ((cur_rank > MAX_RANK) ? MAX_RANK : cur_rank);
    bound = 1;
    for (int a = 0; a < int'(r); a++) begin
      if ($urandom_range(9) == 0) continue;
      if ($urandom_range(4) == 0) begin
        // wide axis, coarse step: all size bits toggle, only a few elements
        size   = $urandom_range(65535, 1);
        mag    = $urandom_range(65535, (size + 1) / 2);
        step_v = $urandom_range(1) ? int'(mag) : -int'(mag);
        if ($urandom_range(1)) begin
          start = $urandom;
          stop  = $urandom;
        end else begin
          start = int'($urandom_range(2 * size)) - int'(size);
          stop  = int'($urandom_range(2 * size)) - int'(size);
        end
        if ((step_v > 0) != (start < stop)) begin
          swap  = start;
          start = stop;
          stop  = swap;
        end
        bound *= 3;
      end else begin
        size   = $urandom_range((r == 1) ? 12 : ((r == 2) ? 5 : 3), 1);
        mag    = $urandom_range(3, 1);
        step_v = $urandom_range(1) ? int'(mag) : -int'(mag);
        lo     = int'($urandom_range(size - 1));
        hi     = int'($urandom_range(size, lo + 1));
        if (step_v > 0) begin
          start = lo;
          stop  = hi;
        end else begin
          start = hi - 1;
          stop  = lo - 1;
        end
        // rewrite bounds in their count-from-the-end or out-of-range forms
        if ($urandom_range(2) == 0) start -= int'(size);
        if (stop == -1)
          stop = -int'(size) - 1 - int'($urandom_range(3));
        else if (stop == int'(size) && $urandom_range(1))
          stop = int'($urandom_range(32'h7FFF_FFFF, size));
        else if (stop < int'(size) && $urandom_range(2) == 0)
          stop -= int'(size);
        if ($urandom_range(7) == 0) begin
          start = int'($urandom_range(2 * size + 4)) - int'(size) - 2;
          stop  = int'($urandom_range(2 * size + 4)) - int'(size) - 2;
        end
        bound *= size;
      end
      load_axis($urandom_range(1) ? a : a - int'(r), size, start, stop, step_v);
    end
    if (bound > 60) bound = 60;
    n = ($urandom_range(3) == 0) ? $urandom_range(bound, 1) : bound + $urandom_range(2, 1);
    repeat (n) request_next();
  endtask

  // Noise: a stray request or a load with anything in it, zero step included.
  task automatic random_noise();
    int step_v;
    if ($urandom_range(1)) begin
      request_next();
    end else begin
      step_v = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(131070)) - 65535;
      load_axis(int'($urandom_range(7)) - 4, $urandom_range(65535), $urandom, $urandom,
                step_v);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_end, guard;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, rank 1 from reset.
    // Untouched descriptor: one element at offset zero, then finished.
    request_next();
    // Zero step on an axis out of range: still rejected with its own status.
    load_axis(2, 4, 0, 4, 0);
    // Axis out of range with a good step: dropped, walk stays finished.
    load_axis(3, 4, 0, 4, 1);
    request_next();
    // Largest size and step, extreme bounds clamp to 0..size.
    load_axis(-1, 65535, int'(32'h8000_0000), int'(32'h7FFF_FFFF), 65535);
    request_next();
    // Size zero leaves the slice empty.
    load_axis(0, 0, 0, 5, 1);
    request_next();
    // Step -65535, bounds clamp to -1..size-1: single element at 9.
    load_axis(0, 10, int'(32'h7FFF_FFFF), int'(32'h8000_0000), -65535);
    request_next();
    // Backward walk 4, 2, 0 from bounds given from the end, then finished.
    load_axis(-1, 5, -1, -7, -2);
    repeat (4) request_next();
    // Start past end with a positive step: empty.
    load_axis(0, 6, 4, 2, 1);
    request_next();
    // Rank four: two loaded axes, two left at reset, 2 x 2 walk and one more.
    write_rank(4);
    load_axis(-4, 2, 0, 2, 1);
    load_axis(1, 2, -1, -3, -1);
    repeat (5) request_next();

    // Random part: four flow-control phases, rank extremes at each start.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      case (p)
        0: write_rank(4);
        1: write_rank(0);
        2: write_rank(7);
        default: write_rank(1);
      endcase
      phase_end = items_sent + ITEM_GOAL / 4;
      while (items_sent < phase_end) begin
        if ($urandom_range(29) == 0) write_rank($urandom_range(7));
        if ($urandom_range(4) == 0) random_noise();
        else random_slice();
      end
    end

    // Drain, then give stray answers a chance to show up.
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
